@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the line assembler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// ante true at an edge implies cons at the same edge
`define ULA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ula assertion failed");

// ante true at an edge implies cons at the next edge
`define ULA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ula assertion failed");

`else

`define ULA_ASSERT_IMP(label, clk, rst, ante, cons)
`define ULA_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/ula_pkg.sv @@
`default_nettype none

package ula_pkg;

  localparam int LINE_CAPACITY = 128;
  localparam int CHUNK_BYTES   = 8;
  localparam int COUNT_BITS    = 24;

  localparam int TOTAL_BITS   = 24;
  localparam int DATA_BITS    = 64;
  localparam int NBYTES_BITS  = 4;
  localparam int LEN_BITS     = $clog2(LINE_CAPACITY + 1);
  localparam int REM_BITS     = $clog2(LINE_CAPACITY + 2);
  localparam int LANE_BITS    = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int WORD_COUNT   = (LINE_CAPACITY + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int WORD_BITS    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int CHUNK_IDX_BITS = $clog2(WORD_COUNT + 1);
  localparam int ADDR_BITS    = WORD_BITS + 1;
  localparam int RAM_DEPTH    = 2 ** ADDR_BITS;
  localparam int WORD_WIDTH   = 8 * CHUNK_BYTES;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = 1;
  localparam int QCNT_BITS    = 2;

  localparam int PADDR_BITS   = 3;
  localparam int REG_IDX_BITS = PADDR_BITS - 2;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_LINE_LENGTH = '0;

  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] MAXLEN_RESET = 8'd128;

  localparam logic REQ_BYTE     = 1'b0;
  localparam logic REQ_END      = 1'b1;
  localparam logic KIND_CHUNK   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [COUNT_BITS-1:0] lines;
    logic [COUNT_BITS-1:0] bytes;
    logic [COUNT_BITS-1:0] noise;
    logic [COUNT_BITS-1:0] framing;
    logic [COUNT_BITS-1:0] overrun;
    logic [COUNT_BITS-1:0] parity;
  } ula_counts_t;

  // queued work: a line flush out of one bank, or an end summary
  typedef struct packed {
    logic                kind;
    logic                bank;
    logic [LEN_BITS-1:0] len;
    ula_counts_t         counts;
  } ula_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ula_q_status_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_BITS-1:0]  addr;
    logic [WORD_WIDTH-1:0] data;
  } ula_ram_wr_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c,
                                                     input logic en);
    return (en && (c != '1)) ? c + 1'b1 : c;
  endfunction

  function automatic logic [TOTAL_BITS-1:0] to_total(input logic [COUNT_BITS-1:0] c);
    return TOTAL_BITS'(c);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ula_in_if.sv @@
`default_nettype none

interface ula_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] byte_value;
  logic       byte_valid;
  logic       noise_error;
  logic       framing_error;
  logic       overrun_error;
  logic       parity_error;

  modport source (
    output valid, req_type, byte_value, byte_valid,
           noise_error, framing_error, overrun_error, parity_error,
    input  ready
  );

  modport sink (
    input  valid, req_type, byte_value, byte_valid,
           noise_error, framing_error, overrun_error, parity_error,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/ula_out_if.sv @@
`default_nettype none

interface ula_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [63:0] chunk_data;
  logic [3:0]  chunk_bytes;
  logic        last_chunk;
  logic [23:0] line_total;
  logic [23:0] byte_total;
  logic [23:0] noise_total;
  logic [23:0] framing_total;
  logic [23:0] overrun_total;
  logic [23:0] parity_total;

  modport source (
    output valid, result_kind, chunk_data, chunk_bytes, last_chunk, line_total,
           byte_total, noise_total, framing_total, overrun_total, parity_total,
    input  ready
  );

  modport sink (
    input  valid, result_kind, chunk_data, chunk_bytes, last_chunk, line_total,
           byte_total, noise_total, framing_total, overrun_total, parity_total,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/ula_ram.sv @@
`default_nettype none

module ula_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/ula_front.sv @@
`default_nettype none

module ula_front import ula_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ula_in_if.sink        in_ch,
  input  logic [7:0]    max_line_length,
  input  ula_q_status_t q_status,
  input  logic          flush_done,
  output logic          push,
  output ula_cmd_t      cmd,
  output ula_ram_wr_t   ram_wr
);

  logic [LEN_BITS-1:0]   fill_len;
  logic [LANE_BITS-1:0]  lane;
  logic [WORD_BITS-1:0]  word;
  logic                  bank;
  logic                  first_cr;
  logic                  busy;
  logic [WORD_WIDTH-1:0] asm_word;
  ula_counts_t           counts;

  logic [8:0]            max_ext;
  logic [8:0]            eff9;
  logic [LEN_BITS-1:0]   eff_len;
  logic                  accept, is_end, is_lf, is_cr;
  logic                  take_byte, split, emit, append, hold;
  logic                  bank_next;
  logic [LANE_BITS-1:0]  lane_base, lane_adv;
  logic [WORD_BITS-1:0]  word_base, word_adv;
  logic                  wrap;
  logic [WORD_WIDTH-1:0] asm_next;
  ula_counts_t           counts_next;

  // one line is flushed at a time; a held byte goes to the other bank when its line is flushed
  assign in_ch.ready = !q_status.full && !busy;

  always_comb begin
    max_ext = {1'b0, max_line_length};
    if (max_ext == '0) begin
      eff9 = 9'd1;
    end else if (max_ext > 9'(LINE_CAPACITY)) begin
      eff9 = 9'(LINE_CAPACITY);
    end else begin
      eff9 = max_ext;
    end
    eff_len = LEN_BITS'(eff9);

    accept    = in_ch.valid && in_ch.ready;
    is_end    = (in_ch.req_type == REQ_END);
    is_lf     = (in_ch.byte_value == CH_LF);
    is_cr     = (in_ch.byte_value == CH_CR);
    take_byte = accept && !is_end && in_ch.byte_valid;
    split     = take_byte && (is_lf || (fill_len >= eff_len));
    // a lone held carriage return strips down to nothing
    emit      = split && (fill_len != '0) &&
                !((fill_len == LEN_BITS'(1)) && first_cr);
    hold      = split && !is_lf;
    append    = take_byte && !split && !is_cr &&
                (fill_len < LEN_BITS'(LINE_CAPACITY));
    bank_next = emit ? ~bank : bank;

    lane_base = hold ? '0 : lane;
    word_base = hold ? '0 : word;
    wrap      = (lane_base == LANE_BITS'(CHUNK_BYTES - 1));
    lane_adv  = wrap ? '0 : lane_base + 1'b1;
    word_adv  = wrap ? word_base + 1'b1 : word_base;

    asm_next = asm_word;
    if (append) begin
      if (lane == '0) begin
        asm_next = '0;
      end
      asm_next[{lane, 3'b000} +: 8] = in_ch.byte_value;
    end else if (hold) begin
      asm_next      = '0;
      asm_next[7:0] = in_ch.byte_value;
    end

    ram_wr.we   = append || hold;
    ram_wr.addr = append ? {bank, word} : {bank_next, WORD_BITS'(0)};
    ram_wr.data = asm_next;

    push        = accept && (is_end || emit);
    cmd.kind    = is_end ? KIND_SUMMARY : KIND_CHUNK;
    cmd.bank    = bank;
    cmd.len     = fill_len;
    cmd.counts  = counts;

    counts_next = counts;
    if (accept) begin
      if (is_end) begin
        counts_next = '0;
      end else begin
        counts_next.noise   = sat_inc(counts.noise, in_ch.noise_error);
        counts_next.framing = sat_inc(counts.framing, in_ch.framing_error);
        counts_next.overrun = sat_inc(counts.overrun, in_ch.overrun_error);
        counts_next.parity  = sat_inc(counts.parity, in_ch.parity_error);
        counts_next.bytes   = sat_inc(counts.bytes, in_ch.byte_valid);
        counts_next.lines   = sat_inc(counts.lines, emit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_len <= '0;
      lane     <= '0;
      word     <= '0;
      bank     <= 1'b0;
      first_cr <= 1'b0;
      busy     <= 1'b0;
      counts   <= '0;
    end else begin
      counts <= counts_next;
      bank   <= bank_next;
      if (accept && is_end) begin
        fill_len <= '0;
        lane     <= '0;
        word     <= '0;
      end else if (split) begin
        if (hold) begin
          fill_len <= LEN_BITS'(1);
          lane     <= lane_adv;
          word     <= word_adv;
          first_cr <= is_cr;
        end else begin
          fill_len <= '0;
          lane     <= '0;
          word     <= '0;
        end
      end else if (append) begin
        fill_len <= fill_len + 1'b1;
        lane     <= lane_adv;
        word     <= word_adv;
        if (fill_len == '0) begin
          first_cr <= 1'b0;
        end
      end
      if (emit) begin
        busy <= 1'b1;
      end else if (flush_done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    asm_word <= asm_next;
  end

endmodule

`default_nettype wire

@@ rtl/core/ula_cmd_queue.sv @@
`default_nettype none

module ula_cmd_queue import ula_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ula_cmd_t      push_cmd,
  input  logic          pop,
  output ula_cmd_t      head,
  output ula_q_status_t status
);

  `include "assert_macros.svh"

  ula_cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wptr;
  logic [QPTR_BITS-1:0]  rptr;
  logic [QCNT_BITS-1:0]  count;

  assign status.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

  `ULA_ASSERT_IMP(a_q_no_overflow, clk, rst, push, !status.full || pop)
  `ULA_ASSERT_IMP(a_q_no_underflow, clk, rst, pop, !status.empty)

endmodule

`default_nettype wire

@@ rtl/core/ula_back.sv @@
`default_nettype none

module ula_back import ula_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ula_q_status_t         q_status,
  input  ula_cmd_t              q_head,
  output logic                  pop,
  output logic [ADDR_BITS-1:0]  ram_raddr,
  input  logic [WORD_WIDTH-1:0] ram_rdata,
  output logic                  flush_done,
  ula_out_if.source             out_ch
);

  `include "assert_macros.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                state;
  logic                      bank;
  logic [CHUNK_IDX_BITS-1:0] idx;
  logic [REM_BITS-1:0]       rem;

  logic                      out_valid;
  logic                      out_kind;
  logic [DATA_BITS-1:0]      out_data;
  logic [NBYTES_BITS-1:0]    out_nbytes;
  logic                      out_last;
  logic [TOTAL_BITS-1:0]     out_lines, out_bytes, out_noise;
  logic [TOTAL_BITS-1:0]     out_framing, out_overrun, out_parity;

  logic                      out_free;
  logic                      load_sum, load_chunk;
  logic                      last;
  logic [NBYTES_BITS-1:0]    nbytes;
  logic [WORD_WIDTH-1:0]     chunk;

  assign out_free  = !out_valid || out_ch.ready;
  assign ram_raddr = {bank, idx[WORD_BITS-1:0]};

  always_comb begin
    pop = (state == ST_IDLE) && !q_status.empty &&
          ((q_head.kind == KIND_CHUNK) || out_free);
    load_sum   = pop && (q_head.kind == KIND_SUMMARY);
    load_chunk = (state == ST_EMIT) && out_free;
    last       = (rem <= REM_BITS'(CHUNK_BYTES));
    nbytes     = last ? NBYTES_BITS'(rem) : NBYTES_BITS'(CHUNK_BYTES);
    flush_done = load_chunk && last;

    // rem counts bytes still owed, the appended line feed included
    chunk = '0;
    for (int i = 0; i < CHUNK_BYTES; i++) begin
      if (REM_BITS'(i) < rem) begin
        if (REM_BITS'(i) == rem - 1'b1) begin
          chunk[i*8 +: 8] = CH_LF;
        end else begin
          chunk[i*8 +: 8] = ram_rdata[i*8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop && (q_head.kind == KIND_CHUNK)) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load_chunk) begin
            state <= last ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (load_sum || load_chunk) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (q_head.kind == KIND_CHUNK)) begin
      bank <= q_head.bank;
      idx  <= '0;
      rem  <= REM_BITS'(q_head.len) + 1'b1;
    end else if (load_chunk) begin
      idx <= idx + 1'b1;
      rem <= rem - REM_BITS'(nbytes);
    end
    if (load_sum) begin
      out_kind    <= KIND_SUMMARY;
      out_data    <= '0;
      out_nbytes  <= '0;
      out_last    <= 1'b0;
      out_lines   <= to_total(q_head.counts.lines);
      out_bytes   <= to_total(q_head.counts.bytes);
      out_noise   <= to_total(q_head.counts.noise);
      out_framing <= to_total(q_head.counts.framing);
      out_overrun <= to_total(q_head.counts.overrun);
      out_parity  <= to_total(q_head.counts.parity);
    end else if (load_chunk) begin
      out_kind    <= KIND_CHUNK;
      out_data    <= DATA_BITS'(chunk);
      out_nbytes  <= nbytes;
      out_last    <= last;
      out_lines   <= '0;
      out_bytes   <= '0;
      out_noise   <= '0;
      out_framing <= '0;
      out_overrun <= '0;
      out_parity  <= '0;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.result_kind   = out_kind;
  assign out_ch.chunk_data    = out_data;
  assign out_ch.chunk_bytes   = out_nbytes;
  assign out_ch.last_chunk    = out_last;
  assign out_ch.line_total    = out_lines;
  assign out_ch.byte_total    = out_bytes;
  assign out_ch.noise_total   = out_noise;
  assign out_ch.framing_total = out_framing;
  assign out_ch.overrun_total = out_overrun;
  assign out_ch.parity_total  = out_parity;

  `ULA_ASSERT_NXT(a_read_then_emit, clk, rst, state == ST_READ, state == ST_EMIT)
  `ULA_ASSERT_IMP(a_chunk_size, clk, rst, load_chunk, (nbytes - 1'b1) < NBYTES_BITS'(CHUNK_BYTES))

endmodule

`default_nettype wire

@@ rtl/core/uart_line_assembler.sv @@
// Channel   Role     Transfer carries
// in_ch     sink     req_type, byte_value, byte_valid, four receiver error flags
// out_ch    source   result_kind, chunk_data/bytes, last_chunk, six totals
// APB       slave    max_line_length at byte address 0
//
// A byte that does not end a line is appended in the front end, CR apart.
// A line flush drains in the back end chunk by chunk (line RAM read,
// then output register load); input transfers stall from the byte that ends
// the line until its last chunk sits in the output register.
// An end summary loads into the free output register once it heads the queue.
// Reset is synchronous; the line RAM needs no clearing.
`default_nettype none

module uart_line_assembler import ula_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  ula_in_if.sink                in_ch,
  ula_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [7:0]            max_line_length;
  logic                  reg_hit;

  logic                  push;
  logic                  pop;
  ula_cmd_t              push_cmd;
  ula_cmd_t              q_head;
  ula_q_status_t         q_status;
  ula_ram_wr_t           ram_wr;
  logic [ADDR_BITS-1:0]  ram_raddr;
  logic [WORD_WIDTH-1:0] ram_rdata;
  logic                  flush_done;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_BITS-1:2] == REG_MAX_LINE_LENGTH);
  assign prdata  = reg_hit ? {24'b0, max_line_length} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_length <= MAXLEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_line_length <= pwdata[7:0];
    end
  end

  ula_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_ch           (in_ch),
    .max_line_length (max_line_length),
    .q_status        (q_status),
    .flush_done      (flush_done),
    .push            (push),
    .cmd             (push_cmd),
    .ram_wr          (ram_wr)
  );

  ula_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .status   (q_status)
  );

  ula_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (RAM_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ula_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .q_head     (q_head),
    .pop        (pop),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .flush_done (flush_done),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

@@ dv/uart_line_assembler_tb.sv @@
`timescale 1ns / 1ps

module uart_line_assembler_tb;
  import ula_pkg::*;

  localparam logic [REG_IDX_BITS-1:0] REG_SPARE = REG_MAX_LINE_LENGTH + 1'b1;

  localparam int NUM_PHASES      = 11;
  localparam int ITEMS_PER_PHASE = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct packed {
    logic       req;
    logic [7:0] value;
    logic       valid;
    logic [3:0] err;   // noise, framing, overrun, parity
  } rx_item_t;

  typedef struct packed {
    logic                  kind;
    logic [63:0]           data;
    logic [3:0]            nbytes;
    logic                  last;
    logic [TOTAL_BITS-1:0] lines;
    logic [TOTAL_BITS-1:0] bytes;
    logic [TOTAL_BITS-1:0] noise;
    logic [TOTAL_BITS-1:0] framing;
    logic [TOTAL_BITS-1:0] overrun;
    logic [TOTAL_BITS-1:0] parity;
  } line_result_t;

  // directed row; when typed, a byte row ends a line in one chunk and an
  // end row reports lines/bytes with the same count for all four errors
  typedef struct packed {
    logic        req;
    logic [7:0]  value;
    logic        valid;
    logic [3:0]  err;
    logic        typed;
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic [23:0] lines;
    logic [23:0] bytes;
    logic [23:0] errs;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  ula_in_if  in_ch ();
  ula_out_if out_ch ();

  uart_line_assembler dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // line assembly state mirrored by the testbench
  logic [7:0]            line_buf [LINE_CAPACITY];
  int                    held_len;
  logic [7:0]            max_len_reg;
  logic [COUNT_BITS-1:0] line_cnt;
  logic [COUNT_BITS-1:0] byte_cnt;
  logic [COUNT_BITS-1:0] err_cnt [3:0];
  line_result_t          awaited_results [$];

  int  fail_count;
  int  sent_count;
  bit  burst_mode;
  bit  hold_off_req;

  logic [7:0] phase_len [NUM_PHASES] = '{8'd128, 8'd0, 8'd1, 8'd9, 8'd8, 8'd255,
                                         8'd200, 8'd17, 8'd2, 8'd128, 8'd64};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic int split_length();
    if (max_len_reg == 0) return 1;
    if (max_len_reg > LINE_CAPACITY) return LINE_CAPACITY;
    return int'(max_len_reg);
  endfunction

  function automatic logic [3:0] rand_err();
    logic [3:0] e;
    int k;
    for (k = 0; k < 4; k++) e[k] = ($urandom_range(0, 15) == 0);
    return e;
  endfunction

  function automatic logic [7:0] rand_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 92) return CH_CR;
    return 8'($urandom_range(0, 255));
  endfunction

  // queue the chunks of the held line, trailing CR/LF stripped, LF appended
  task automatic emit_line();
    int len, total, n, pos, i;
    line_result_t r;
    len = held_len;
    while (len > 0 && (line_buf[len-1] == CH_CR || line_buf[len-1] == CH_LF)) len--;
    if (len == 0) return;
    total = len + 1;
    for (pos = 0; pos < total; pos += CHUNK_BYTES) begin
      n = (total - pos > CHUNK_BYTES) ? CHUNK_BYTES : total - pos;
      r = '0;
      r.kind = KIND_CHUNK;
      for (i = 0; i < n; i++) r.data[8*i +: 8] = (pos + i < len) ? line_buf[pos+i] : CH_LF;
      r.nbytes = 4'(n);
      r.last = (pos + n == total);
      awaited_results.push_back(r);
    end
    line_cnt = count_up(line_cnt);
  endtask

  task automatic assemble_step(input rx_item_t it);
    line_result_t r;
    int k;
    if (it.req == REQ_END) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      r.lines = line_cnt;
      r.bytes = byte_cnt;
      r.noise = err_cnt[3];
      r.framing = err_cnt[2];
      r.overrun = err_cnt[1];
      r.parity = err_cnt[0];
      awaited_results.push_back(r);
      held_len = 0;
      line_cnt = '0;
      byte_cnt = '0;
      for (k = 0; k < 4; k++) err_cnt[k] = '0;
      return;
    end
    for (k = 0; k < 4; k++) begin
      if (it.err[k]) err_cnt[k] = count_up(err_cnt[k]);
    end
    if (!it.valid) return;
    byte_cnt = count_up(byte_cnt);
    if (it.value == CH_LF || held_len >= split_length()) begin
      emit_line();
      held_len = 0;
      // the byte that split the line opens the next one, CR included
      if (it.value != CH_LF) begin
        line_buf[0] = it.value;
        held_len = 1;
      end
    end else if (it.value != CH_CR && held_len < LINE_CAPACITY) begin
      line_buf[held_len] = it.value;
      held_len++;
    end
  endtask

  task automatic send_item(input rx_item_t it);
    int gap, r;
    gap = 0;
    if (!burst_mode) begin
      r = $urandom_range(0, 19);
      if (r >= 18) gap = $urandom_range(6, 30);
      else if (r >= 12) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= it.req;
    in_ch.byte_value    <= it.value;
    in_ch.byte_valid    <= it.valid;
    in_ch.noise_error   <= it.err[3];
    in_ch.framing_error <= it.err[2];
    in_ch.overrun_error <= it.err[1];
    in_ch.parity_error  <= it.err[0];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic offer(input rx_item_t it);
    send_item(it);
    assemble_step(it);
    sent_count++;
  endtask

  task automatic release_input();
    @(negedge clk) in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] word);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_readback();
    logic [31:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_MAX_LINE_LENGTH, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {24'd0, max_len_reg}) begin
      $error("max_line_length readback: expected %0h, got %0h", max_len_reg, got);
      fail_count++;
    end
  endtask

  task automatic program_max_length(input logic [31:0] word);
    apb_write(REG_MAX_LINE_LENGTH, word);
    max_len_reg = word[7:0];
    check_readback();
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // output side: ready pattern, with one long hold-off on request
  initial begin : sink_ready
    int hold_left, stall_left;
    bit hold_taken;
    hold_left = 0;
    stall_left = 0;
    hold_taken = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (burst_mode || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end
    end
  end

  always @(posedge clk) begin : result_check
    line_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing outstanding: kind %0d data %0h",
               out_ch.result_kind, out_ch.chunk_data);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("result_kind", 64'(want.kind), 64'(out_ch.result_kind));
        check_field("chunk_data", want.data, out_ch.chunk_data);
        check_field("chunk_bytes", 64'(want.nbytes), 64'(out_ch.chunk_bytes));
        check_field("last_chunk", 64'(want.last), 64'(out_ch.last_chunk));
        check_field("line_total", 64'(want.lines), 64'(out_ch.line_total));
        check_field("byte_total", 64'(want.bytes), 64'(out_ch.byte_total));
        check_field("noise_total", 64'(want.noise), 64'(out_ch.noise_total));
        check_field("framing_total", 64'(want.framing), 64'(out_ch.framing_total));
        check_field("overrun_total", 64'(want.overrun), 64'(out_ch.overrun_total));
        check_field("parity_total", 64'(want.parity), 64'(out_ch.parity_total));
      end
    end
  end

  initial begin : stimulus
    dir_row_t     dir_rows [25];
    dir_row_t     row;
    rx_item_t     it;
    line_result_t want;
    logic [31:0]  word;
    int           idx, ph, lim, len, pick, term, i, n0;
    bit           forced;

    fail_count   = 0;
    sent_count   = 0;
    burst_mode   = 1'b0;
    hold_off_req = 1'b0;
    held_len     = 0;
    line_cnt     = '0;
    byte_cnt     = '0;
    for (i = 0; i < 4; i++) err_cnt[i] = '0;
    max_len_reg  = MAXLEN_RESET;

    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_ch.valid         = 1'b0;
    in_ch.req_type      = REQ_BYTE;
    in_ch.byte_value    = '0;
    in_ch.byte_valid    = 1'b0;
    in_ch.noise_error   = 1'b0;
    in_ch.framing_error = 1'b0;
    in_ch.overrun_error = 1'b0;
    in_ch.parity_error  = 1'b0;

    // directed rows run with a 3-byte line limit so splits come early
    dir_rows = '{
      '{REQ_END,  8'h00, 1'b0, 4'b0000, 1'b1, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, 8'hFF, 1'b0, 4'b1111, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, 8'h41, 1'b1, 4'b0000, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, CH_CR, 1'b1, 4'b0000, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, 8'h00, 1'b1, 4'b0000, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, CH_LF, 1'b1, 4'b0000, 1'b1, 64'h0A0041,   4'd3, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, CH_LF, 1'b1, 4'b0000, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, 8'hFF, 1'b1, 4'b0000, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, 8'h42, 1'b1, 4'b0000, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, 8'h43, 1'b1, 4'b0000, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, CH_CR, 1'b1, 4'b0000, 1'b1, 64'h0A4342FF, 4'd4, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, CH_LF, 1'b1, 4'b0000, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, 8'h78, 1'b1, 4'b1000, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, 8'h79, 1'b1, 4'b0100, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, 8'h7A, 1'b1, 4'b0010, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, 8'h77, 1'b1, 4'b0001, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, 8'h71, 1'b1, 4'b0000, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, 8'h72, 1'b1, 4'b0000, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, CH_LF, 1'b1, 4'b0000, 1'b1, 64'h0A727177, 4'd4, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, 8'h6B, 1'b1, 4'b0000, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_END,  8'h00, 1'b0, 4'b0000, 1'b1, 64'h0,        4'd0, 24'd4, 24'd18, 24'd2},
      '{REQ_BYTE, 8'h6D, 1'b1, 4'b0000, 1'b0, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0},
      '{REQ_BYTE, CH_LF, 1'b1, 4'b0000, 1'b1, 64'h0A6D,     4'd2, 24'd0, 24'd0,  24'd0},
      '{REQ_END,  8'h00, 1'b0, 4'b0000, 1'b1, 64'h0,        4'd0, 24'd1, 24'd2,  24'd0},
      '{REQ_END,  8'h55, 1'b1, 4'b1111, 1'b1, 64'h0,        4'd0, 24'd0, 24'd0,  24'd0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    program_max_length(32'd3);
    for (idx = 0; idx < 25; idx++) begin
      row = dir_rows[idx];
      it = {row.req, row.value, row.valid, row.err};
      send_item(it);
      n0 = awaited_results.size();
      assemble_step(it);
      if (row.typed) begin
        while (awaited_results.size() > n0) void'(awaited_results.pop_back());
        want = '0;
        if (row.req == REQ_END) begin
          want.kind = KIND_SUMMARY;
          want.lines = row.lines;
          want.bytes = row.bytes;
          want.noise = row.errs;
          want.framing = row.errs;
          want.overrun = row.errs;
          want.parity = row.errs;
        end else begin
          want.kind = KIND_CHUNK;
          want.data = row.data;
          want.nbytes = row.nbytes;
          want.last = 1'b1;
        end
        awaited_results.push_back(want);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      release_input();
      wait_drained();
      // junk in the upper bits of the write data
      word = $urandom();
      word[7:0] = phase_len[ph];
      program_max_length(word);
      if (ph == 6) begin
        apb_write(REG_SPARE, $urandom());
        check_readback();
      end
      burst_mode = (ph % 4 == 3);
      if (ph == 2) hold_off_req = 1'b1;
      lim = split_length();
      sent_count = 0;
      while (sent_count < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        it = '0;
        if (pick < 3) begin
          it.req = REQ_END;
          it.value = 8'($urandom_range(0, 255));
          it.valid = 1'($urandom_range(0, 1));
          it.err = 4'($urandom_range(0, 15));
          offer(it);
        end else if (pick < 12) begin
          it.req = REQ_BYTE;
          it.value = 8'($urandom_range(0, 255));
          it.valid = 1'b0;
          it.err = 4'($urandom_range(0, 15));
          offer(it);
        end else begin
          // one full-length line in phases 0 and 5 gives the longest flush
          forced = (sent_count == 0 && (ph == 0 || ph == 5));
          if (forced) len = lim;
          else if ($urandom_range(0, (lim <= 20) ? 9 : 24) == 0) len = lim - 1 + $urandom_range(0, 2);
          else len = $urandom_range(0, 12);
          for (i = 0; i < len; i++) begin
            it.req = REQ_BYTE;
            it.valid = 1'b1;
            it.value = forced ? 8'($urandom_range(8'h20, 8'h7E)) : rand_text_byte();
            it.err = rand_err();
            offer(it);
          end
          term = $urandom_range(0, 9);
          it.req = REQ_BYTE;
          it.valid = 1'b1;
          it.err = rand_err();
          if (term >= 6 && term < 8) begin
            it.value = CH_CR;
            offer(it);
          end
          if (term < 8) begin
            it.value = CH_LF;
            offer(it);
          end
        end
      end
    end

    release_input();
    wait_drained();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
